// ===== design/asd_pkg.sv =====
package asd_pkg;

  localparam int AXIS_WIDTH      = 16;
  localparam int TIME_WIDTH      = 32;
  localparam int MAG_WIDTH       = 16;
  localparam int MODE_WIDTH      = 4;
  localparam int COUNT_WIDTH     = 5;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // radix-4 serial square and root
  localparam int SQ_STEPS    = (AXIS_WIDTH + 1) / 2;
  localparam int DIGIT_WIDTH = 2 * SQ_STEPS;
  localparam int SUM_WIDTH   = 2 * DIGIT_WIDTH;
  localparam int ROOT_WIDTH  = DIGIT_WIDTH;
  localparam int ROOT_STEPS  = ROOT_WIDTH;
  localparam int REM_WIDTH   = ROOT_WIDTH + 1;
  localparam int STEP_WIDTH  = $clog2(ROOT_STEPS);

  localparam int MAG_MAX  = (1 << MAG_WIDTH) - 1;
  localparam int MODE_MAX = 1 << MODE_WIDTH;

  localparam logic [CFG_WIDTH-1:0]   THRESHOLD_RESET  = 16'd8192;
  localparam logic [CFG_WIDTH-1:0]   HOLDOFF_RESET    = 16'd1000;
  localparam logic [CFG_WIDTH-1:0]   INTERVAL_RESET   = 16'd50;
  localparam logic [COUNT_WIDTH-1:0] MODE_COUNT_RESET = 5'd9;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_HOLDOFF    = 2'd1,
    CFG_INTERVAL   = 2'd2,
    CFG_MODE_COUNT = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAG,
    ST_DECIDE
  } top_state_t;

  typedef enum logic [1:0] {
    MAG_IDLE,
    MAG_SQUARE,
    MAG_ROOT
  } mag_state_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]        now_ms;
    logic                         read_ok;
    logic signed [AXIS_WIDTH-1:0] accel_x;
    logic signed [AXIS_WIDTH-1:0] accel_y;
    logic signed [AXIS_WIDTH-1:0] accel_z;
  } asd_in_t;

  typedef struct packed {
    logic                  checked;
    logic                  shake;
    logic [MODE_WIDTH-1:0] mode_index;
    logic [MAG_WIDTH-1:0]  magnitude;
  } asd_out_t;

  function automatic logic [DIGIT_WIDTH-1:0] axis_abs(input logic [AXIS_WIDTH-1:0] raw);
    logic [AXIS_WIDTH-1:0] mag;
    mag = raw[AXIS_WIDTH-1] ? (~raw + 1'b1) : raw;
    return DIGIT_WIDTH'(mag);
  endfunction

  function automatic logic [DIGIT_WIDTH+1:0] digit_mul(input logic [DIGIT_WIDTH-1:0] a,
                                                       input logic [1:0]             d);
    logic [DIGIT_WIDTH+1:0] a1;
    logic [DIGIT_WIDTH+1:0] p;
    a1 = (DIGIT_WIDTH + 2)'(a);
    case (d)
      2'd0:    p = '0;
      2'd1:    p = a1;
      2'd2:    p = a1 << 1;
      2'd3:    p = (a1 << 1) + a1;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [MAG_WIDTH-1:0] root_sat(input logic [ROOT_WIDTH-1:0] root);
    logic [63:0] ext;
    ext = 64'(root);
    return (ext > 64'(MAG_MAX)) ? {MAG_WIDTH{1'b1}} : ext[MAG_WIDTH-1:0];
  endfunction

endpackage

// ===== design/asd_magnitude.sv =====
module asd_magnitude (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [asd_pkg::AXIS_WIDTH-1:0] accel_x,
  input  logic signed [asd_pkg::AXIS_WIDTH-1:0] accel_y,
  input  logic signed [asd_pkg::AXIS_WIDTH-1:0] accel_z,
  output logic                                  done,
  output logic [asd_pkg::MAG_WIDTH-1:0]         magnitude
);

  asd_pkg::mag_state_t state, state_next;

  logic [asd_pkg::STEP_WIDTH-1:0]  step;
  logic [asd_pkg::DIGIT_WIDTH-1:0] ax, ay, az;
  logic [asd_pkg::DIGIT_WIDTH-1:0] dx, dy, dz;
  logic [asd_pkg::SUM_WIDTH-1:0]   acc;
  logic [asd_pkg::REM_WIDTH-1:0]   rem;
  logic [asd_pkg::ROOT_WIDTH-1:0]  root;

  logic sq_en, root_en, last_sq, last_root;

  logic [asd_pkg::SUM_WIDTH-1:0]   acc_sq_next;
  logic [asd_pkg::DIGIT_WIDTH+3:0] terms;
  logic [asd_pkg::REM_WIDTH+1:0]   rem_sh, trial, rem_diff;
  logic                            take;
  logic [asd_pkg::REM_WIDTH-1:0]   rem_next;
  logic [asd_pkg::ROOT_WIDTH-1:0]  root_next;

  always_comb begin
    state_next = state;
    case (state)
      asd_pkg::MAG_IDLE:   if (start) state_next = asd_pkg::MAG_SQUARE;
      asd_pkg::MAG_SQUARE: if (last_sq) state_next = asd_pkg::MAG_ROOT;
      asd_pkg::MAG_ROOT:   if (last_root) state_next = asd_pkg::MAG_IDLE;
      default:             state_next = asd_pkg::MAG_IDLE;
    endcase
  end

  always_comb begin
    sq_en     = 1'b0;
    root_en   = 1'b0;
    last_sq   = 1'b0;
    last_root = 1'b0;
    case (state)
      asd_pkg::MAG_SQUARE: begin
        sq_en   = 1'b1;
        last_sq = (step == asd_pkg::STEP_WIDTH'(asd_pkg::SQ_STEPS - 1));
      end
      asd_pkg::MAG_ROOT: begin
        root_en   = 1'b1;
        last_root = (step == asd_pkg::STEP_WIDTH'(asd_pkg::ROOT_STEPS - 1));
      end
      default: begin
      end
    endcase
  end

  // Horner over 2-bit digits of each axis, MSB first
  always_comb begin
    terms = (asd_pkg::DIGIT_WIDTH + 4)'(asd_pkg::digit_mul(ax, dx[asd_pkg::DIGIT_WIDTH-1 -: 2]))
          + (asd_pkg::DIGIT_WIDTH + 4)'(asd_pkg::digit_mul(ay, dy[asd_pkg::DIGIT_WIDTH-1 -: 2]))
          + (asd_pkg::DIGIT_WIDTH + 4)'(asd_pkg::digit_mul(az, dz[asd_pkg::DIGIT_WIDTH-1 -: 2]));
    acc_sq_next = (acc << 2) + asd_pkg::SUM_WIDTH'(terms);
  end

  // restoring root, two radicand bits per step
  always_comb begin
    rem_sh    = {rem, acc[asd_pkg::SUM_WIDTH-1 -: 2]};
    trial     = (asd_pkg::REM_WIDTH + 2)'({root, 2'b01});
    take      = (rem_sh >= trial);
    rem_diff  = rem_sh - trial;
    rem_next  = take ? rem_diff[asd_pkg::REM_WIDTH-1:0] : rem_sh[asd_pkg::REM_WIDTH-1:0];
    root_next = {root[asd_pkg::ROOT_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asd_pkg::MAG_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= root_en && last_root;
      if (start || (sq_en && last_sq) || (root_en && last_root)) begin
        step <= '0;
      end else if (sq_en || root_en) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax  <= asd_pkg::axis_abs(accel_x);
      ay  <= asd_pkg::axis_abs(accel_y);
      az  <= asd_pkg::axis_abs(accel_z);
      dx  <= asd_pkg::axis_abs(accel_x);
      dy  <= asd_pkg::axis_abs(accel_y);
      dz  <= asd_pkg::axis_abs(accel_z);
      acc <= '0;
    end else if (sq_en) begin
      acc <= acc_sq_next;
      dx  <= dx << 2;
      dy  <= dy << 2;
      dz  <= dz << 2;
      if (last_sq) begin
        rem  <= '0;
        root <= '0;
      end
    end else if (root_en) begin
      acc  <= acc << 2;
      rem  <= rem_next;
      root <= root_next;
      if (last_root) magnitude <= asd_pkg::root_sat(root_next);
    end
  end

endmodule

// ===== design/accel_shake_detector.sv =====
// From request accept to result, a checked good read goes through
//   8 square steps, 16 root steps, handoff and decide; other reads go straight to decide.
// A new request is taken only once the last one is decided, and decide waits while a
//   held result is not taken; the serial square/root unit holds one request at a time.
// Reset (rst, sync, active high): config to defaults, times, previous magnitude
//   and mode to zero, output empty.
module accel_shake_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  asd_pkg::asd_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output asd_pkg::asd_out_t                    out_data,
  input  logic                                 cfg_write,
  input  logic [asd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [asd_pkg::CFG_WIDTH-1:0]        cfg_data
);

  asd_pkg::top_state_t state, state_next;

  logic [asd_pkg::CFG_WIDTH-1:0]   shake_threshold;
  logic [asd_pkg::CFG_WIDTH-1:0]   holdoff_ms;
  logic [asd_pkg::CFG_WIDTH-1:0]   check_interval_ms;
  logic [asd_pkg::COUNT_WIDTH-1:0] mode_count;

  logic [asd_pkg::TIME_WIDTH-1:0] last_check_time;
  logic [asd_pkg::TIME_WIDTH-1:0] last_shake_time;
  logic [asd_pkg::MAG_WIDTH-1:0]  previous_magnitude;
  logic [asd_pkg::MODE_WIDTH-1:0] current_mode;

  logic [asd_pkg::TIME_WIDTH-1:0] now_r;
  logic                           checked_r;
  logic                           good_r;

  logic                          accept, gate_open, mag_start, mag_done, decide;
  logic [asd_pkg::MAG_WIDTH-1:0] mag_root;

  logic [asd_pkg::TIME_WIDTH-1:0]  check_elapsed, shake_elapsed;
  logic [asd_pkg::MAG_WIDTH-1:0]   mag_val, delta;
  logic                            shake;
  logic [asd_pkg::COUNT_WIDTH-1:0] count_eff, mode_inc;
  logic [asd_pkg::MODE_WIDTH-1:0]  mode_next;

  assign accept        = in_valid && in_ready;
  assign check_elapsed = in_data.now_ms - last_check_time;
  assign gate_open     = check_elapsed > asd_pkg::TIME_WIDTH'(check_interval_ms);

  asd_magnitude u_magnitude (
    .clk       (clk),
    .rst       (rst),
    .start     (mag_start),
    .accel_x   (in_data.accel_x),
    .accel_y   (in_data.accel_y),
    .accel_z   (in_data.accel_z),
    .done      (mag_done),
    .magnitude (mag_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      asd_pkg::ST_IDLE:
        if (accept) state_next = mag_start ? asd_pkg::ST_MAG : asd_pkg::ST_DECIDE;
      asd_pkg::ST_MAG:
        if (mag_done) state_next = asd_pkg::ST_DECIDE;
      asd_pkg::ST_DECIDE:
        if (decide) state_next = asd_pkg::ST_IDLE;
      default:
        state_next = asd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mag_start = 1'b0;
    decide    = 1'b0;
    case (state)
      asd_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        mag_start = in_valid && gate_open && in_data.read_ok;
      end
      asd_pkg::ST_DECIDE: decide = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    mag_val       = good_r ? mag_root : '0;
    delta         = (mag_val > previous_magnitude) ? (mag_val - previous_magnitude)
                                                   : (previous_magnitude - mag_val);
    shake_elapsed = now_r - last_shake_time;
    shake         = good_r && (previous_magnitude != '0) && (delta > shake_threshold) &&
                    (shake_elapsed > asd_pkg::TIME_WIDTH'(holdoff_ms));
    if (mode_count == '0) begin
      count_eff = asd_pkg::COUNT_WIDTH'(1);
    end else if (mode_count > asd_pkg::COUNT_WIDTH'(asd_pkg::MODE_MAX)) begin
      count_eff = asd_pkg::COUNT_WIDTH'(asd_pkg::MODE_MAX);
    end else begin
      count_eff = mode_count;
    end
    mode_inc  = asd_pkg::COUNT_WIDTH'(current_mode) + 1'b1;
    mode_next = (mode_inc >= count_eff) ? '0 : mode_inc[asd_pkg::MODE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= asd_pkg::ST_IDLE;
      out_valid          <= 1'b0;
      shake_threshold    <= asd_pkg::THRESHOLD_RESET;
      holdoff_ms         <= asd_pkg::HOLDOFF_RESET;
      check_interval_ms  <= asd_pkg::INTERVAL_RESET;
      mode_count         <= asd_pkg::MODE_COUNT_RESET;
      last_check_time    <= '0;
      last_shake_time    <= '0;
      previous_magnitude <= '0;
      current_mode       <= '0;
    end else begin
      state <= state_next;
      if (decide) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          asd_pkg::CFG_THRESHOLD:  shake_threshold   <= cfg_data;
          asd_pkg::CFG_HOLDOFF:    holdoff_ms        <= cfg_data;
          asd_pkg::CFG_INTERVAL:   check_interval_ms <= cfg_data;
          asd_pkg::CFG_MODE_COUNT: mode_count        <= cfg_data[asd_pkg::COUNT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (decide) begin
        if (checked_r) last_check_time <= now_r;
        if (good_r) previous_magnitude <= mag_val;
        if (shake) begin
          last_shake_time <= now_r;
          current_mode    <= mode_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r     <= in_data.now_ms;
      checked_r <= gate_open;
      good_r    <= gate_open && in_data.read_ok;
    end
    if (decide) begin
      out_data.checked    <= checked_r;
      out_data.shake      <= shake;
      out_data.mode_index <= shake ? mode_next : current_mode;
      out_data.magnitude  <= mag_val;
    end
  end

endmodule

// ===== design/asd_checker.sv =====
module asd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input asd_pkg::asd_out_t                   out_data
);

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_shake_needs_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.shake) |-> (out_data.checked && out_data.magnitude != '0 ||
                                       out_data.checked))
    else $error("shake on unchecked sample");

  a_unchecked_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.checked) |-> (!out_data.shake && out_data.magnitude == '0))
    else $error("unchecked sample carries data");

endmodule

bind accel_shake_detector asd_checker u_asd_checker (.*);
